// ===== design/pngunf_pkg.sv =====
// ----------------------------------------------------------------------------
// pngunf_pkg - shared types and constants
// Sizes, filter codes, register indexes and the item passed from the
// position tracker to the reconstruction stage.
// ----------------------------------------------------------------------------
package pngunf_pkg;

    localparam int MAX_ROW_BYTES = 16384;
    localparam int MAX_ROWS      = 4096;
    localparam int HIST_DEPTH    = 4;

    localparam int ADDR_W  = $clog2(MAX_ROW_BYTES);
    localparam int COL_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CFG_W   = 15;
    localparam int BPP_W   = 3;
    localparam int RB_W    = 15;
    localparam int RT_W    = 13;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW_BYTES       = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW_TOTAL       = 2'd2;

    // filter type codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    typedef enum logic [1:0] {
        KIND_FILTER,
        KIND_SAMPLE,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        sbyte;
        logic [2:0]        filt;
        logic              upper_ok;
        logic              row_end;
        logic              img_end;
        logic [ADDR_W-1:0] addr;
    } item_t;

endpackage

// ===== design/pngunf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pngunf_ctrl - position tracker
// Follows column, row, row filter and error state per accepted beat and
// classifies each beat for the reconstruction stage.
// ----------------------------------------------------------------------------
module pngunf_ctrl
    import pngunf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       stream_byte,
    input  logic             image_start,
    input  logic [COL_W-1:0] row_bytes_eff,
    input  logic [ROW_W:0]   row_total_eff,
    output logic             load,
    output item_t            item
);

    logic [COL_W-1:0] col_reg, col_next, col_eff;
    logic [ROW_W-1:0] row_reg, row_next, row_eff;
    logic [2:0]       filt_reg, filt_next;
    logic             err_reg, err_next, err_eff;
    logic             live;

    always_comb begin
        col_eff   = image_start ? '0 : col_reg;
        row_eff   = image_start ? '0 : row_reg;
        err_eff   = image_start ? 1'b0 : err_reg;
        col_next  = col_eff;
        row_next  = row_eff;
        filt_next = filt_reg;
        err_next  = err_eff;
        live      = 1'b0;

        item.kind     = KIND_FILTER;
        item.sbyte    = stream_byte;
        item.filt     = filt_reg;
        item.upper_ok = (row_eff != '0);
        item.row_end  = 1'b0;
        item.img_end  = 1'b0;
        item.addr     = ADDR_W'(col_eff - COL_W'(1));

        if (!err_eff) begin
            live = 1'b1;
            if (col_eff == '0) begin
                if (stream_byte > {5'b0, FILT_PAETH}) begin
                    item.kind = KIND_ERROR;
                    err_next  = 1'b1;
                end else begin
                    item.kind = KIND_FILTER;
                    filt_next = stream_byte[2:0];
                    col_next  = COL_W'(1);
                end
            end else begin
                item.kind = KIND_SAMPLE;
                if (col_eff >= row_bytes_eff) begin
                    item.row_end = 1'b1;
                    col_next     = '0;
                    if (({1'b0, row_eff} + (ROW_W+1)'(1)) >= row_total_eff) begin
                        item.img_end = 1'b1;
                        row_next     = '0;
                    end else begin
                        row_next = row_eff + ROW_W'(1);
                    end
                end else begin
                    col_next = col_eff + COL_W'(1);
                end
            end
        end
        load = accept && live;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            filt_reg <= FILT_NONE;
            err_reg  <= 1'b0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            filt_reg <= filt_next;
            err_reg  <= err_next;
        end
    end

endmodule

// ===== design/pngunf_store.sv =====
// ----------------------------------------------------------------------------
// pngunf_store - previous-row line store
// One write port, one registered read port; a read at the address being
// written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module pngunf_store
    import pngunf_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MAX_ROW_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pngunf_recon.sv =====
// ----------------------------------------------------------------------------
// pngunf_recon - reconstruction stage and result register
// Holds one classified beat with its upper byte, applies the row filter
// using the left and upper-left histories, and loads the result register.
// ----------------------------------------------------------------------------
module pngunf_recon
    import pngunf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  item_t             item,
    input  logic [7:0]        upper_byte,
    input  logic              bpp4,
    output logic              stage_free,
    output logic              st_we,
    output logic [ADDR_W-1:0] st_waddr,
    output logic [7:0]        st_wdata,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_pixel_byte,
    output logic              m_row_end,
    output logic              m_image_end,
    output logic              m_bad_filter
);

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] p, pa, pb, pc, cc;
        begin
            pa = (b > c) ? 10'(b - c) : 10'(c - b);
            pb = (a > c) ? 10'(a - c) : 10'(c - a);
            p  = 10'(a) + 10'(b);
            cc = 10'(c) + 10'(c);
            pc = (p > cc) ? (p - cc) : (cc - p);
            if (pa <= pb && pa <= pc) begin
                paeth = a;
            end else if (pb <= pc) begin
                paeth = b;
            end else begin
                paeth = c;
            end
        end
    endfunction

    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic [7:0] left_reg  [HIST_DEPTH];
    logic [7:0] ulft_reg  [HIST_DEPTH];
    logic       advance;
    logic [7:0] a, b, c, pred, val;
    logic [8:0] avg_sum;

    logic       m_valid_reg;
    logic [7:0] m_pixel_reg;
    logic       m_row_end_reg, m_image_end_reg, m_bad_reg;

    assign advance    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign stage_free = !s1_valid_reg || advance;

    always_comb begin
        a       = bpp4 ? left_reg[3] : left_reg[2];
        c       = bpp4 ? ulft_reg[3] : ulft_reg[2];
        b       = s1_item_reg.upper_ok ? upper_byte : 8'd0;
        avg_sum = 9'(a) + 9'(b);
        unique case (s1_item_reg.filt)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        val = s1_item_reg.sbyte + pred;
    end

    assign st_we    = advance && (s1_item_reg.kind == KIND_SAMPLE);
    assign st_waddr = s1_item_reg.addr;
    assign st_wdata = val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (load) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_item_reg <= item;
        end
    end

    // newest entry first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                left_reg[i] <= 8'd0;
                ulft_reg[i] <= 8'd0;
            end
        end else if (advance) begin
            if (s1_item_reg.kind == KIND_SAMPLE) begin
                left_reg[0] <= val;
                ulft_reg[0] <= b;
                for (int i = 1; i < HIST_DEPTH; i++) begin
                    left_reg[i] <= left_reg[i-1];
                    ulft_reg[i] <= ulft_reg[i-1];
                end
            end else begin
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    left_reg[i] <= 8'd0;
                    ulft_reg[i] <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= (s1_item_reg.kind != KIND_FILTER);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s1_item_reg.kind == KIND_SAMPLE) begin
                m_pixel_reg     <= val;
                m_row_end_reg   <= s1_item_reg.row_end;
                m_image_end_reg <= s1_item_reg.img_end;
                m_bad_reg       <= 1'b0;
            end else begin
                m_pixel_reg     <= 8'd0;
                m_row_end_reg   <= 1'b0;
                m_image_end_reg <= 1'b0;
                m_bad_reg       <= 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_byte = m_pixel_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_image_end  = m_image_end_reg;
    assign m_bad_filter = m_bad_reg;

endmodule

// ===== design/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter - PNG scanline filter reconstruction
// Undoes the per-row PNG filters on a decompressed byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry one decompressed byte each. The first
//   byte of a row is its filter type; s_image_start marks the type byte of
//   row 0 and clears position and error state. Each sample byte yields one
//   result beat (m_valid/m_ready); type bytes yield none, except an unknown
//   type, which yields one beat with m_bad_filter set, after which input is
//   swallowed until the next image start.
//   Throughput: one byte per clock while m_ready stays high. A result passes
//   through the input stage, with the line store's registered read, and then
//   the result register.
//   The previous row lives in a single-port-write, single-read line store of
//   MAX_ROW_BYTES bytes; its read is issued in the accept cycle, which sets
//   the two-stage depth.
//   Stall: while m_ready is low the result register holds, the input stage
//   fills, and s_ready drops only when both are occupied.
//   Reset (aresetn low, synchronous): pipeline emptied, position cleared,
//   registers back to bytes_per_pixel 4, row_bytes 16384, row_total 1. Write
//   configuration (cfg_we/cfg_index/cfg_wdata) only while idle; not enforced.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import pngunf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_stream_byte,
    input  logic             s_image_start,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_pixel_byte,
    output logic             m_row_end,
    output logic             m_image_end,
    output logic             m_bad_filter
);

    logic [BPP_W-1:0] bpp_reg;
    logic [RB_W-1:0]  row_bytes_reg;
    logic [RT_W-1:0]  row_total_reg;

    logic             bpp4;
    logic [COL_W-1:0] row_bytes_eff;
    logic [ROW_W:0]   row_total_eff;

    logic              accept, load, stage_free;
    item_t             item;
    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr;
    logic [7:0]        st_wdata, upper_byte;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= BPP_W'(4);
            row_bytes_reg <= RB_W'(MAX_ROW_BYTES);
            row_total_reg <= RT_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg       <= cfg_wdata[BPP_W-1:0];
                REG_ROW_BYTES:       row_bytes_reg <= cfg_wdata[RB_W-1:0];
                REG_ROW_TOTAL:       row_total_reg <= cfg_wdata[RT_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range values clamp to the nearest legal setting
    always_comb begin
        bpp4 = (bpp_reg > BPP_W'(3));
        if (row_bytes_reg == '0) begin
            row_bytes_eff = COL_W'(1);
        end else if (row_bytes_reg > RB_W'(MAX_ROW_BYTES)) begin
            row_bytes_eff = COL_W'(MAX_ROW_BYTES);
        end else begin
            row_bytes_eff = COL_W'(row_bytes_reg);
        end
        if (row_total_reg == '0) begin
            row_total_eff = (ROW_W+1)'(1);
        end else if (row_total_reg > RT_W'(MAX_ROWS)) begin
            row_total_eff = (ROW_W+1)'(MAX_ROWS);
        end else begin
            row_total_eff = (ROW_W+1)'(row_total_reg);
        end
    end

    // input stage may take a beat whenever it is empty or draining this cycle
    assign s_ready = stage_free;
    assign accept  = s_valid && s_ready;

    pngunf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .stream_byte   (s_stream_byte),
        .image_start   (s_image_start),
        .row_bytes_eff (row_bytes_eff),
        .row_total_eff (row_total_eff),
        .load          (load),
        .item          (item)
    );

    // row 0 never reads the store
    assign st_re = load && (item.kind == KIND_SAMPLE) && item.upper_ok;

    pngunf_store u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (item.addr),
        .rdata (upper_byte)
    );

    pngunf_recon u_recon (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .item         (item),
        .upper_byte   (upper_byte),
        .bpp4         (bpp4),
        .stage_free   (stage_free),
        .st_we        (st_we),
        .st_waddr     (st_waddr),
        .st_wdata     (st_wdata),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_pixel_byte (m_pixel_byte),
        .m_row_end    (m_row_end),
        .m_image_end  (m_image_end),
        .m_bad_filter (m_bad_filter)
    );

`ifndef ASSERT_OFF
    // error beat carries nothing else
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_filter) |-> (m_pixel_byte == 8'd0 && !m_row_end && !m_image_end))
        else $error("error beat carries sample data");

    // last byte of the image is always the last byte of a row
    a_img_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_image_end) |-> m_row_end)
        else $error("image end without row end");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // a beat only enters when the input stage is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> stage_free)
        else $error("input stage overwritten");
`endif

endmodule
